FILE: rtl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types and constants of the attribute pair splitter.
// ----------------------------------------------------------------------------
package gaps_pkg;

   // Characters that the parser reacts to.
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // Codes of the kind field of a response.
   localparam logic [1:0] KIND_KEY      = 2'd0;
   localparam logic [1:0] KIND_VALUE    = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;
   localparam logic [1:0] KIND_REC_END  = 2'd3;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_EMIT,
      ST_OVF,
      ST_END
   } state_type;

   // Summary of the buffered fragment, valid once the last byte is stored.
   typedef struct packed {
      logic overflow;
      logic pair_ok;
   } frag_flags_type;

endpackage

FILE: rtl/gaps_if.sv
// ----------------------------------------------------------------------------
// gaps_req_if / gaps_rsp_if
// Valid/ready channels for request bytes and response items.
// ----------------------------------------------------------------------------
interface gaps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       record_last;

   modport source (output valid, output text_byte, output record_last, input ready);
   modport sink   (input valid, input text_byte, input record_last, output ready);
endinterface

interface gaps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       pair_last;

   modport source (output valid, output out_byte, output kind, output pair_last, input ready);
   modport sink   (input valid, input out_byte, input kind, input pair_last, output ready);
endinterface

FILE: rtl/gaps_frag_buf.sv
// ----------------------------------------------------------------------------
// gaps_frag_buf
// Fragment memory with the position trackers that are updated as bytes
// are stored, so that the pair bounds are known when the fragment ends.
// ----------------------------------------------------------------------------
module gaps_frag_buf #(
   parameter int FRAGMENT_MAX = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [7:0]                         push_byte,
   input  logic                               clear,
   input  logic                               rd_en,
   input  logic [$clog2(FRAGMENT_MAX)-1:0]    rd_addr,
   output logic [7:0]                         rd_data,
   output gaps_pkg::frag_flags_type           flags,
   output logic [$clog2(FRAGMENT_MAX)-1:0]    first_pos,
   output logic [$clog2(FRAGMENT_MAX)-1:0]    q1_pos,
   output logic [$clog2(FRAGMENT_MAX)-1:0]    q2_pos,
   output logic [$clog2(FRAGMENT_MAX):0]      key_end
);

   localparam int IDX_W = $clog2(FRAGMENT_MAX);
   localparam int LEN_W = IDX_W + 1;

   logic [7:0]       mem [FRAGMENT_MAX];
   logic [7:0]       rd_data_ff;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             nb_seen_ff, nb_seen_in;
   logic             q_seen_ff, q_seen_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] q1_ff, q1_in;
   logic [IDX_W-1:0] q2_ff, q2_in;
   logic [LEN_W-1:0] kend_ff, kend_in;

   logic             full;
   logic             store;
   logic             blank;
   logic             quote;
   logic [IDX_W-1:0] wr_addr;

   assign full    = (len_ff == LEN_W'(FRAGMENT_MAX));
   assign store   = push && !ovf_ff && !full;
   assign blank   = (push_byte == gaps_pkg::CH_SPACE) || (push_byte == gaps_pkg::CH_TAB);
   assign quote   = (push_byte == gaps_pkg::CH_QUOTE);
   assign wr_addr = len_ff[IDX_W-1:0];

   always_comb begin
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      nb_seen_in = nb_seen_ff;
      q_seen_in  = q_seen_ff;
      first_in   = first_ff;
      q1_in      = q1_ff;
      q2_in      = q2_ff;
      kend_in    = kend_ff;
      if (clear) begin
         len_in     = '0;
         ovf_in     = 1'b0;
         nb_seen_in = 1'b0;
         q_seen_in  = 1'b0;
      end else if (push && !ovf_ff && full) begin
         ovf_in = 1'b1;
      end else if (store) begin
         len_in = len_ff + LEN_W'(1);
         if (!blank && !nb_seen_ff) begin
            nb_seen_in = 1'b1;
            first_in   = wr_addr;
         end
         if (quote) begin
            if (!q_seen_ff) begin
               q_seen_in = 1'b1;
               q1_in     = wr_addr;
            end
            q2_in = wr_addr;
         end else if (!blank && !q_seen_ff) begin
            // Key text ends after the last non-blank byte before the first quote.
            kend_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         nb_seen_ff <= 1'b0;
         q_seen_ff  <= 1'b0;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         nb_seen_ff <= nb_seen_in;
         q_seen_ff  <= q_seen_in;
      end
      first_ff <= first_in;
      q1_ff    <= q1_in;
      q2_ff    <= q2_in;
      kend_ff  <= kend_in;
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem[wr_addr] <= push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign first_pos = first_ff;
   assign q1_pos    = q1_ff;
   assign q2_pos    = q2_ff;
   assign key_end   = kend_ff;

   // A pair needs a key before the first quote and a non-empty value
   // between two distinct quotes.
   assign flags.overflow = ovf_ff;
   assign flags.pair_ok  = nb_seen_ff && q_seen_ff && (q1_ff != first_ff) &&
                           (q2_ff != q1_ff) &&
                           ({1'b0, q2_ff} != ({1'b0, q1_ff} + LEN_W'(1))) &&
                           (kend_ff != {1'b0, first_ff});

endmodule

FILE: rtl/gtf_attribute_pair_splitter_unit.sv
// ----------------------------------------------------------------------------
// gtf_attribute_pair_splitter_unit
// Splits an attribute column into key and value bytes, one pair per fragment.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Fields                          Meaning
//   req_chan  in   text_byte, record_last          one byte of attribute text
//   rsp_chan  out  out_byte, kind, pair_last       key/value byte or marker
//
// A byte that does not end a fragment is stored as it is taken. When a ';' or
// the last byte of a record arrives, a decision state follows, then each key
// or value byte is read from memory, then emitted; an escape pair goes through
// read and emit twice for its single response. Overflow and record-end markers
// have states of their own. Reset is synchronous and needs no clearing pass.
// A stalled response holds the sequencer in place; no request is taken until
// a fragment is fully emitted.
//
module gtf_attribute_pair_splitter_unit #(
   parameter int FRAGMENT_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   gaps_req_if.sink    req_chan,
   gaps_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(FRAGMENT_MAX);
   localparam int LEN_W = IDX_W + 1;

   gaps_pkg::state_type      state_ff, state_in;
   gaps_pkg::frag_flags_type flags;

   logic             rec_last_ff, rec_last_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic             val_ph_ff, val_ph_in;
   logic             hold_ff, hold_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic [1:0]       rsp_kind_ff;
   logic             rsp_last_ff;

   logic             accept;
   logic             push;
   logic             clear;
   logic             rd_en;
   logic [7:0]       md;
   logic [IDX_W-1:0] first_pos, q1_pos, q2_pos;
   logic [LEN_W-1:0] key_end;

   logic             out_free;
   logic [LEN_W-1:0] nxt_ptr;
   logic             at_vend;
   logic             esc_pair;
   logic             esc_flush;
   logic             hold_set;
   logic             emit_go;
   logic [7:0]       emit_byte;
   logic [1:0]       emit_kind;
   logic             emit_last;
   gaps_pkg::state_type finish_target;

   // Fragment memory and its trackers.
   gaps_frag_buf #(
      .FRAGMENT_MAX (FRAGMENT_MAX)
   ) u_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_byte (req_chan.text_byte),
      .clear     (clear),
      .rd_en     (rd_en),
      .rd_addr   (ptr_ff[IDX_W-1:0]),
      .rd_data   (md),
      .flags     (flags),
      .first_pos (first_pos),
      .q1_pos    (q1_pos),
      .q2_pos    (q2_pos),
      .key_end   (key_end)
   );

   // Requests are only taken while no fragment is being emitted, so the
   // memory is never written and read for the same entry at once.
   assign req_chan.ready = (state_ff == gaps_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = accept && (req_chan.text_byte != gaps_pkg::CH_SEMI);
   assign clear          = (state_ff == gaps_pkg::ST_DECIDE);
   assign rd_en          = (state_ff == gaps_pkg::ST_READ);

   // The output register may be refilled in the cycle it is drained.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Escape handling: a backslash inside the value is held back for one
   // byte. If that byte is a quote or a backslash, only it is sent;
   // otherwise the backslash goes out alone and the byte is looked at again.
   assign nxt_ptr   = ptr_ff + LEN_W'(1);
   assign at_vend   = (nxt_ptr >= {1'b0, q2_pos});
   assign esc_pair  = hold_ff && ((md == gaps_pkg::CH_QUOTE) || (md == gaps_pkg::CH_BSLASH));
   assign esc_flush = hold_ff && !esc_pair;
   assign hold_set  = val_ph_ff && !hold_ff && (md == gaps_pkg::CH_BSLASH) && !at_vend;

   assign finish_target = rec_last_ff ? gaps_pkg::ST_END : gaps_pkg::ST_IDLE;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gaps_pkg::ST_IDLE: begin
            if (accept && ((req_chan.text_byte == gaps_pkg::CH_SEMI) ||
                           req_chan.record_last)) begin
               state_in = gaps_pkg::ST_DECIDE;
            end
         end
         gaps_pkg::ST_DECIDE: begin
            if (flags.overflow) begin
               state_in = gaps_pkg::ST_OVF;
            end else if (flags.pair_ok) begin
               state_in = gaps_pkg::ST_READ;
            end else begin
               state_in = finish_target;
            end
         end
         gaps_pkg::ST_READ: begin
            state_in = gaps_pkg::ST_EMIT;
         end
         gaps_pkg::ST_EMIT: begin
            if (hold_set) begin
               state_in = gaps_pkg::ST_READ;
            end else if (emit_go && !esc_flush) begin
               if (val_ph_ff && at_vend) begin
                  state_in = finish_target;
               end else begin
                  state_in = gaps_pkg::ST_READ;
               end
            end
         end
         gaps_pkg::ST_OVF: begin
            if (out_free) begin
               state_in = finish_target;
            end
         end
         gaps_pkg::ST_END: begin
            if (out_free) begin
               state_in = gaps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gaps_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates of the sequencer.
   always_comb begin
      rec_last_in = rec_last_ff;
      ptr_in      = ptr_ff;
      val_ph_in   = val_ph_ff;
      hold_in     = hold_ff;
      emit_go     = 1'b0;
      emit_byte   = md;
      emit_kind   = gaps_pkg::KIND_KEY;
      emit_last   = 1'b0;
      unique case (state_ff)
         gaps_pkg::ST_IDLE: begin
            if (accept) begin
               rec_last_in = req_chan.record_last;
            end
         end
         gaps_pkg::ST_DECIDE: begin
            ptr_in    = {1'b0, first_pos};
            val_ph_in = 1'b0;
            hold_in   = 1'b0;
         end
         gaps_pkg::ST_READ: begin
         end
         gaps_pkg::ST_EMIT: begin
            if (!val_ph_ff) begin
               emit_go = out_free;
               if (out_free) begin
                  if (nxt_ptr == key_end) begin
                     ptr_in    = {1'b0, q1_pos} + LEN_W'(1);
                     val_ph_in = 1'b1;
                  end else begin
                     ptr_in = nxt_ptr;
                  end
               end
            end else if (esc_flush) begin
               emit_byte = gaps_pkg::CH_BSLASH;
               emit_kind = gaps_pkg::KIND_VALUE;
               emit_go   = out_free;
               if (out_free) begin
                  hold_in = 1'b0;
               end
            end else if (hold_set) begin
               hold_in = 1'b1;
               ptr_in  = nxt_ptr;
            end else begin
               emit_kind = gaps_pkg::KIND_VALUE;
               emit_last = at_vend;
               emit_go   = out_free;
               if (out_free) begin
                  hold_in = 1'b0;
                  ptr_in  = nxt_ptr;
               end
            end
         end
         gaps_pkg::ST_OVF: begin
            emit_byte = 8'h00;
            emit_kind = gaps_pkg::KIND_OVERFLOW;
            emit_go   = out_free;
         end
         gaps_pkg::ST_END: begin
            emit_byte = 8'h00;
            emit_kind = gaps_pkg::KIND_REC_END;
            emit_go   = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit_go || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gaps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         val_ph_ff    <= 1'b0;
         hold_ff      <= 1'b0;
         rec_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         val_ph_ff    <= val_ph_in;
         hold_ff      <= hold_in;
         rec_last_ff  <= rec_last_in;
      end
      ptr_ff <= ptr_in;
      if (emit_go) begin
         rsp_byte_ff <= emit_byte;
         rsp_kind_ff <= emit_kind;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = rsp_byte_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.pair_last = rsp_last_ff;

   // A response is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> out_free)
      else $error("response register overwritten while stalled");

   // The memory is read only at addresses inside the buffer.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gaps_pkg::ST_READ) |-> (ptr_ff < LEN_W'(FRAGMENT_MAX)))
      else $error("fragment read beyond buffer");

   // Only value bytes close a pair.
   a_pair_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pair_last) |-> (rsp_chan.kind == gaps_pkg::KIND_VALUE))
      else $error("pair_last on a non-value response");

   // The last byte of a record always starts fragment processing.
   a_last_finishes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.record_last) |=> (state_ff == gaps_pkg::ST_DECIDE))
      else $error("record end not processed");

endmodule

FILE: dv/tb_gtf_attribute_pair_splitter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gtf_attribute_pair_splitter_unit
// Self-checking bench for the attribute pair splitter. Requests are bytes of
// attribute text. A scoreboard class predicts the key, value and marker items
// for every accepted request, and checks each response in order.
// Directed fragments come first. Random records follow: mostly well-formed
// pairs, with some broken fragments, noise bytes and over-long fragments.
// Both channels idle at random, and there is a steady stretch, a long
// response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_gtf_attribute_pair_splitter_unit;

   // Fragment capacity of the block at its default parameter value.
   localparam int FRAG_CAP = 64;
   localparam int RANDOM_BYTES = 80;
   localparam int HOLD_CYCLES = 400;

   // One request: a text byte and its end-of-record flag.
   typedef struct packed {
      logic [7:0] text;
      logic       last_flag;
   } text_req_type;

   // One response item as the block emits it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       pair_last;
   } pair_item_type;

   // -------------------------------------------------------------------------
   // The scoreboard keeps its own copy of the fragment buffer and works out
   // the items that each accepted request causes. Responses are compared
   // against the oldest item still due.
   // -------------------------------------------------------------------------
   class splitter_scoreboard;
      logic [7:0]    frag_bytes[FRAG_CAP];
      int            frag_len;
      bit            frag_overflow;
      pair_item_type items_due[$];
      int            errors;
      int            n_requests;
      int            n_results;
      int            n_pairs;
      int            n_overflow;
      int            n_records;

      function bit is_blank(logic [7:0] c);
         return c == gaps_pkg::CH_SPACE || c == gaps_pkg::CH_TAB;
      endfunction

      function void add_item(logic [7:0] b, logic [1:0] k, logic pl);
         pair_item_type it;
         it.out_byte  = b;
         it.kind      = k;
         it.pair_last = pl;
         items_due.insert(items_due.size(), it);
      endfunction

      // Trims, locates the quotes and emits the pair of the buffered
      // fragment, or a single overflow marker.
      function void end_fragment();
         int         len, first, tail, q1, q2, kend, j, adv;
         logic [7:0] c, nx;
         len = frag_len;
         frag_len = 0;
         if (frag_overflow) begin
            frag_overflow = 0;
            add_item(8'h00, gaps_pkg::KIND_OVERFLOW, 1'b0);
            return;
         end
         first = 0;
         while (first < len && is_blank(frag_bytes[first])) first++;
         if (first >= len) return;
         tail = len - 1;
         while (tail > first && is_blank(frag_bytes[tail])) tail--;
         q1 = first;
         while (q1 <= tail && frag_bytes[q1] != gaps_pkg::CH_QUOTE) q1++;
         if (q1 > tail || q1 == first) return;
         q2 = tail;
         while (q2 > q1 && frag_bytes[q2] != gaps_pkg::CH_QUOTE) q2--;
         if (q2 == q1) return;
         kend = q1;
         while (kend > first && is_blank(frag_bytes[kend - 1])) kend--;
         if (kend == first || q2 == q1 + 1) return;
         for (j = first; j < kend; j++) add_item(frag_bytes[j], gaps_pkg::KIND_KEY, 1'b0);
         j = q1 + 1;
         while (j < q2) begin
            c = frag_bytes[j];
            adv = 1;
            if (c == gaps_pkg::CH_BSLASH && j + 1 < q2) begin
               nx = frag_bytes[j + 1];
               if (nx == gaps_pkg::CH_QUOTE || nx == gaps_pkg::CH_BSLASH) begin
                  c = nx;
                  adv = 2;
               end
            end
            add_item(c, gaps_pkg::KIND_VALUE, (j + adv >= q2));
            j += adv;
         end
      endfunction

      function void note_request(text_req_type rq);
         n_requests++;
         if (rq.text == gaps_pkg::CH_SEMI) begin
            end_fragment();
         end else begin
            if (!frag_overflow) begin
               if (frag_len >= FRAG_CAP) begin
                  frag_overflow = 1;
               end else begin
                  frag_bytes[frag_len] = rq.text;
                  frag_len++;
               end
            end
            if (rq.last_flag) end_fragment();
         end
         if (rq.last_flag) add_item(8'h00, gaps_pkg::KIND_REC_END, 1'b0);
      endfunction

      function void check_response(pair_item_type got);
         pair_item_type want;
         n_results++;
         if (items_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected response byte=%h kind=%0d pair_last=%0b",
                        got.out_byte, got.kind, got.pair_last);
            return;
         end
         want = items_due.pop_front();
         if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
             got.pair_last !== want.pair_last) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: response %0d expected byte=%h kind=%0d pair_last=%0b,",
                        n_results, want.out_byte, want.kind, want.pair_last);
               $display("       got byte=%h kind=%0d pair_last=%0b",
                        got.out_byte, got.kind, got.pair_last);
            end
         end
         if (want.pair_last) n_pairs++;
         if (want.kind == gaps_pkg::KIND_OVERFLOW) n_overflow++;
         if (want.kind == gaps_pkg::KIND_REC_END) n_records++;
      endfunction

      function int pending();
         return items_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   gaps_req_if req_if ();
   gaps_rsp_if rsp_if ();

   gtf_attribute_pair_splitter_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   splitter_scoreboard sb;
   text_req_type       stim_q[$];

   // Steady makes both sides run without idling; hold_req asks the response
   // side for one long stretch with ready low.
   bit steady;
   bit hold_req;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A generous ceiling on the whole run.
   initial begin
      #20_000_000;
      $display("Timeout with %0d responses still due.", sb.pending());
      $display("Regression FAIL");
      $finish;
   end

   // Both channels are sampled at the rising edge, where the block's own
   // registers have not yet moved. Requests and responses are paired up here.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_request({req_if.text_byte, req_if.record_last});
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response({rsp_if.out_byte, rsp_if.kind, rsp_if.pair_last});
   end

   // Response side: random back-pressure, a steady stretch, and one long
   // hold-off that this process counts out itself.
   initial begin
      int hold_left;
      bit hold_started;
      hold_left = 0;
      hold_started = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (steady || reset) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= 20);
         end
      end
   end

   // Offers one request and waits until it is taken. Called just after a
   // falling edge and returns just after one. Valid stays high between
   // back-to-back requests, so each step sees at most one assignment.
   task automatic send_req(input text_req_type rq);
      if (!steady) begin
         while ($urandom_range(99, 0) < 20) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid       <= 1'b1;
      req_if.text_byte   <= rq.text;
      req_if.record_last <= rq.last_flag;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic send_queue();
      text_req_type rq;
      while (stim_q.size() > 0) begin
         rq = stim_q.pop_front();
         send_req(rq);
      end
      req_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_byte(input logic [7:0] b);
      stim_q.insert(stim_q.size(), {b, 1'b0});
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Marks the newest queued byte as the final byte of the record.
   task automatic mark_last();
      text_req_type rq;
      rq = stim_q.pop_back();
      rq.last_flag = 1'b1;
      stim_q.insert(stim_q.size(), rq);
   endtask

   task automatic add_blanks(input int hi);
      int i, n;
      n = $urandom_range(hi, 0);
      for (i = 0; i < n; i++)
         add_byte($urandom_range(1, 0) ? gaps_pkg::CH_SPACE : gaps_pkg::CH_TAB);
   endtask

   // Any byte except a separator or a quote; letters half of the time.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      if ($urandom_range(1, 0)) return 8'h61 + 8'($urandom_range(25, 0));
      do c = 8'($urandom_range(255, 0));
      while (c == gaps_pkg::CH_SEMI || c == gaps_pkg::CH_QUOTE);
      return c;
   endfunction

   // A well-formed pair with random blanks, escapes, lone backslashes and
   // embedded quotes in the value.
   task automatic add_pair_fragment();
      int i, n;
      add_blanks(2);
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++) add_byte(plain_char());
      add_blanks(2);
      add_byte(gaps_pkg::CH_QUOTE);
      n = $urandom_range(8, 1);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(19, 0))
            0, 1: begin
               add_byte(gaps_pkg::CH_BSLASH);
               add_byte(gaps_pkg::CH_QUOTE);
            end
            2, 3: begin
               add_byte(gaps_pkg::CH_BSLASH);
               add_byte(gaps_pkg::CH_BSLASH);
            end
            4: add_byte(gaps_pkg::CH_BSLASH);
            5: add_byte(gaps_pkg::CH_QUOTE);
            default: add_byte(plain_char());
         endcase
      end
      add_byte(gaps_pkg::CH_QUOTE);
      add_blanks(2);
   endtask

   // One of the shapes that the block must skip.
   task automatic add_broken_fragment();
      int i, n;
      n = $urandom_range(4, 1);
      case ($urandom_range(5, 0))
         0: add_blanks(4);
         1: for (i = 0; i < n; i++) add_byte(plain_char());
         2: begin
            add_blanks(1);
            add_byte(gaps_pkg::CH_QUOTE);
            for (i = 0; i < n; i++) add_byte(plain_char());
            add_byte(gaps_pkg::CH_QUOTE);
         end
         3: begin
            for (i = 0; i < n; i++) add_byte(plain_char());
            add_byte(gaps_pkg::CH_QUOTE);
            for (i = 0; i < n; i++) add_byte(plain_char());
         end
         4: begin
            for (i = 0; i < n; i++) add_byte(plain_char());
            add_byte(gaps_pkg::CH_SPACE);
            add_byte(gaps_pkg::CH_QUOTE);
            add_byte(gaps_pkg::CH_QUOTE);
         end
         default: begin
            add_blanks(2);
            add_byte(gaps_pkg::CH_TAB);
            add_byte(gaps_pkg::CH_QUOTE);
            add_byte(plain_char());
            add_byte(gaps_pkg::CH_QUOTE);
         end
      endcase
   endtask

   // A pair of the given total length; more than the capacity overflows.
   task automatic add_long_fragment(input int total);
      int i;
      add_text("kk \"");
      for (i = 0; i < total - 5; i++) add_byte(8'h78);
      add_byte(gaps_pkg::CH_QUOTE);
   endtask

   // A random record of one to four fragments. The last one ends either on
   // a separator or on its own final byte.
   task automatic build_record();
      int f, nfrag, i, n, pick;
      nfrag = $urandom_range(4, 1);
      for (f = 0; f < nfrag; f++) begin
         pick = $urandom_range(99, 0);
         if (pick < 70) begin
            add_pair_fragment();
         end else if (pick < 84) begin
            add_broken_fragment();
         end else if (pick < 97) begin
            n = $urandom_range(10, 1);
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(255, 0)));
         end else begin
            add_long_fragment($urandom_range(70, 60));
         end
         if (f < nfrag - 1 || stim_q.size() == 0 || $urandom_range(1, 0))
            add_byte(gaps_pkg::CH_SEMI);
      end
      mark_last();
   endtask

   initial begin
      int  random_bytes;
      bit  hold_done;
      bit  pause_done;

      sb = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.text_byte = 8'h00;
      req_if.record_last = 1'b0;
      steady = 1'b0;
      hold_req = 1'b0;
      random_bytes = 0;
      hold_done = 1'b0;
      pause_done = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed record: a minimal pair, trimming of spaces and tabs,
      // escaped quote and backslash with a lone backslash, embedded quotes,
      // then every shape that is skipped.
      add_text("a \"b\";");
      add_text(" \tgene_id \t\"g1\" \t;");
      add_text("k \"x\\\"y\\\\z\\q\";");
      add_text("k \"a\"b\"c\";");
      add_text(" \t ;");
      add_text("noquote;");
      add_text("\"lead\" x;");
      add_text("k \"one;");
      add_text(" \t\"v\";");
      add_text("k \"\";");
      // A backslash right before the closing quote stays as it is.
      add_text("k \"\\\";");
      // Extreme byte values in key and value; the record ends on a separator.
      add_byte(8'h00);
      add_byte(gaps_pkg::CH_SPACE);
      add_byte(gaps_pkg::CH_QUOTE);
      add_byte(8'hFF);
      add_byte(gaps_pkg::CH_QUOTE);
      add_byte(gaps_pkg::CH_SEMI);
      mark_last();
      // The last byte is not a separator: it is stored, then the pair ends.
      add_text("tid \"t1\"");
      mark_last();
      // A record that is nothing but its separator.
      add_byte(gaps_pkg::CH_SEMI);
      mark_last();
      // A fragment that fills the buffer exactly, then one byte too many
      // arriving as the last byte of the record.
      add_long_fragment(FRAG_CAP);
      add_byte(gaps_pkg::CH_SEMI);
      add_long_fragment(FRAG_CAP);
      add_byte(8'h7A);
      mark_last();
      // An overflow ended by a separator, followed by a normal pair.
      add_long_fragment(FRAG_CAP + 6);
      add_byte(gaps_pkg::CH_SEMI);
      add_text("p \"q\"");
      mark_last();
      send_queue();

      // Random records. Part of the way in, both sides run steady; later
      // the response side holds off while requests keep coming, and after
      // that the request side waits until everything due has arrived.
      while (random_bytes < RANDOM_BYTES) begin
         steady = (random_bytes >= 10 && random_bytes < 40);
         if (!hold_done && random_bytes >= 45) begin
            hold_req = 1'b1;
            hold_done = 1'b1;
         end
         build_record();
         random_bytes += stim_q.size();
         send_queue();
         if (!pause_done && random_bytes >= 60) begin
            pause_done = 1'b1;
            while (sb.pending() != 0) @(negedge clock);
         end
      end
      steady = 1'b0;

      // Wait for the last items, then give the block time to show any
      // response that should not be there.
      while (sb.pending() != 0) @(negedge clock);
      repeat (300) @(negedge clock);

      $display("Sent %0d request bytes in %0d records; checked %0d responses.",
               sb.n_requests, sb.n_records, sb.n_results);
      $display("Saw %0d complete pairs and %0d overflow drops; %0d mismatches.",
               sb.n_pairs, sb.n_overflow, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/gaps_pkg.sv
rtl/gaps_if.sv
rtl/gaps_frag_buf.sv
rtl/gtf_attribute_pair_splitter_unit.sv
dv/tb_gtf_attribute_pair_splitter_unit.sv
